// ----- rtl/core/dat_pkg.sv -----
// Shared types and codes for the delivery ack timeout tracker.
`timescale 1ns / 1ps
package dat_pkg;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_SUCCESS  = 2'd1;
  localparam logic [1:0] KIND_FAILURE  = 2'd2;
  localparam logic [1:0] KIND_FULL     = 2'd3;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [31:0] TIMEOUT_RESET = 32'd200;

  typedef struct packed {
    logic set;
    logic clr;
    logic load_mark;
    logic walk;
    logic kill;
  } dat_cmd_t;

endpackage

// ----- rtl/core/dat_cell.sv -----
// One table slot: pending flag, start time, expiry mark and sweep token.
`timescale 1ns / 1ps
module dat_cell
  import dat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dat_cmd_t    cmd,
  input  logic        sel,
  input  logic [31:0] now,
  input  logic [31:0] timeout,
  input  logic        token_in,
  output logic        valid,
  output logic        token,
  output logic        hit,
  output logic        rest
);

  logic        valid_r, valid_nxt;
  logic        mark_r, mark_nxt;
  logic        token_r, token_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;

  assign elapsed = now - start_r;
  assign valid   = valid_r;
  assign token   = token_r;
  assign hit     = token_r & mark_r;
  assign rest    = mark_r & ~token_r;

  always_comb begin
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    token_nxt = token_r;
    start_nxt = start_r;
    if (cmd.set && sel) begin
      valid_nxt = 1'b1;
      start_nxt = now;
    end
    if (cmd.clr && sel) begin
      valid_nxt = 1'b0;
    end
    if (cmd.load_mark) begin
      mark_nxt  = valid_r && (elapsed > timeout);
      token_nxt = sel;
    end else if (cmd.walk) begin
      // pass the token on; the holder drops its entry when it reports
      token_nxt = token_in;
      if (hit) valid_nxt = 1'b0;
      mark_nxt = cmd.kill ? 1'b0 : rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
      token_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
      token_r <= token_nxt;
    end
    start_r <= start_nxt;
  end

endmodule

// ----- rtl/core/delivery_ack_timeout_tracker.sv -----
// Top level of the delivery ack timeout tracker: sequencing, ack match and sweep walk.
//
//   channel  handshake            payload
//   input    start & !busy        in_op, in_ack_seq, in_current_time
//   result   out_valid strobe     out_kind, out_seq_number, out_last
//   config   cfg_valid/cfg_ready  cfg_data (timeout_ticks)
//
// Send and ack may follow each other every cycle while busy is low;
// the result appears on the cycle after the input beat.
// A sweep first marks the expired slots, then the token walks the row of
// cells one slot a cycle, oldest first; busy is high while it walks and each
// failure appears in the cycle after its slot is visited.
// Synchronous reset clears all slots at once; no clearing pass is needed.
// The result side cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
module delivery_ack_timeout_tracker
  import dat_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_ack_seq,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_seq_number,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = IDX_W + 1;

  logic [31:0]      timeout_r;
  logic [31:0]      next_seq_r, next_seq_nxt;
  logic [IDX_W-1:0] next_slot_r, next_slot_nxt;
  logic             sweeping_r, sweeping_nxt;
  logic [31:0]      walk_seq_r, walk_seq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [31:0]      out_seq_r, out_seq_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  dat_cmd_t         cmd;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] ack_slot;
  logic [SUM_W-1:0] ack_sum;
  logic [31:0]      ack_age;
  logic             ack_in_win;
  logic             slot_busy;
  logic             ack_match;
  logic             any_hit, any_rest, last_hit;

  logic [WINDOW-1:0] sel_vec, valid_vec, token_vec, hit_vec, rest_vec, token_in_vec;

  assign accept    = start && !busy;
  assign busy      = sweeping_r;
  assign cfg_ready = 1'b1;

  // pending seqs have ages 1..WINDOW, so the slot follows from the age
  assign ack_age    = next_seq_r - in_ack_seq;
  assign ack_in_win = (ack_age != 32'd0) && (ack_age <= 32'(WINDOW));
  assign ack_sum    = SUM_W'(next_slot_r) + SUM_W'(WINDOW) - ack_age[SUM_W-1:0];
  assign ack_slot   = (ack_sum >= SUM_W'(WINDOW)) ? IDX_W'(ack_sum - SUM_W'(WINDOW))
                                                  : IDX_W'(ack_sum);

  assign sel_idx   = (in_op == OP_ACK) ? ack_slot : next_slot_r;
  assign slot_busy = valid_vec[next_slot_r];
  assign ack_match = ack_in_win && valid_vec[ack_slot];

  assign any_hit  = |hit_vec;
  assign any_rest = |rest_vec;
  assign last_hit = any_hit && (!any_rest || (cnt_r == CNT_W'(MAX_RESULTS - 1)));

  always_comb begin
    cmd.set       = accept && (in_op == OP_SEND) && !slot_busy;
    cmd.clr       = accept && (in_op == OP_ACK) && ack_match;
    cmd.load_mark = accept && (in_op == OP_SWEEP);
    cmd.walk      = sweeping_r;
    cmd.kill      = last_hit;
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      assign sel_vec[gi]      = (sel_idx == IDX_W'(gi));
      assign token_in_vec[gi] = token_vec[(gi + WINDOW - 1) % WINDOW];
      dat_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sel      (sel_vec[gi]),
        .now      (in_current_time),
        .timeout  (timeout_r),
        .token_in (token_in_vec[gi]),
        .valid    (valid_vec[gi]),
        .token    (token_vec[gi]),
        .hit      (hit_vec[gi]),
        .rest     (rest_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    next_seq_nxt  = next_seq_r;
    next_slot_nxt = next_slot_r;
    sweeping_nxt  = sweeping_r;
    walk_seq_nxt  = walk_seq_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    if (sweeping_r) begin
      walk_seq_nxt = walk_seq_r + 32'd1;
      sweeping_nxt = any_rest && !last_hit;
      if (any_hit) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_FAILURE;
        out_seq_nxt   = walk_seq_r;
        out_last_nxt  = last_hit;
        cnt_nxt       = cnt_r + CNT_W'(1);
      end
    end else if (accept) begin
      case (in_op)
        OP_SEND: begin
          out_valid_nxt = 1'b1;
          out_seq_nxt   = next_seq_r;
          out_last_nxt  = 1'b1;
          if (slot_busy) begin
            out_kind_nxt = KIND_FULL;
          end else begin
            out_kind_nxt  = KIND_ASSIGNED;
            next_seq_nxt  = next_seq_r + 32'd1;
            next_slot_nxt = (next_slot_r == IDX_W'(WINDOW - 1)) ? '0
                                                                : next_slot_r + IDX_W'(1);
          end
        end
        OP_ACK: begin
          if (ack_match) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_SUCCESS;
            out_seq_nxt   = in_ack_seq;
            out_last_nxt  = 1'b1;
          end
        end
        OP_SWEEP: begin
          // start at the oldest slot; walk only if some slot is pending
          sweeping_nxt = |(valid_vec);
          walk_seq_nxt = next_seq_r - 32'(WINDOW);
          cnt_nxt      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      next_seq_r  <= '0;
      next_slot_r <= '0;
      sweeping_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      next_seq_r  <= next_seq_nxt;
      next_slot_r <= next_slot_nxt;
      sweeping_r  <= sweeping_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_seq_r <= walk_seq_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_seq_number = out_seq_r;
  assign out_last       = out_last_r;

endmodule

// ----- rtl/core/dat_checker.sv -----
// Port-level checks for the delivery ack timeout tracker, bound to the top level.
`timescale 1ns / 1ps
module dat_checker
  import dat_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic        out_last
);

  // only a sweep beat makes the block busy
  a_busy_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_op == OP_SWEEP)))
    else $error("busy rose without a sweep beat");

  // a send beat answers on the next cycle with one final result
  a_send_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_SEND)) |=>
      (out_valid && out_last && ((out_kind == KIND_ASSIGNED) || (out_kind == KIND_FULL))))
    else $error("send beat without assigned or full result");

  // a failure that is not the final one leaves the walk running
  a_fail_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_FAILURE) && !out_last) |-> busy)
    else $error("sweep stopped before its final failure");

  // failures come only from a sweep
  a_fail_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_FAILURE)) |-> $past(busy))
    else $error("failure result outside a sweep");

endmodule

bind delivery_ack_timeout_tracker dat_checker u_dat_checker (.*);

// ----- test/delivery_ack_timeout_tracker_test.sv -----
// Self-checking testbench for the delivery ack timeout tracker: sends, acks and timeout sweeps.
`timescale 1ns / 1ps
module delivery_ack_timeout_tracker_test;
  import dat_pkg::*;

  localparam int unsigned WINDOW      = 16;
  localparam int          QUIET_LIMIT = 2000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  // How the driver fills in ack_seq for an ack beat
  localparam logic [1:0] ACK_AS_GIVEN = 2'd0;
  localparam logic [1:0] ACK_LIVE     = 2'd1;
  localparam logic [1:0] ACK_ALIAS    = 2'd2;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ack;
    logic [31:0] stamp;
    logic [1:0]  ack_mode;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic        last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_SEND;
  logic [31:0] in_ack_seq = '0;
  logic [31:0] in_current_time = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_seq_number;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the tracker table
  logic [31:0] m_timeout;
  logic [31:0] m_next_seq;
  logic        m_live [WINDOW];
  logic [31:0] m_seq  [WINDOW];
  logic [31:0] m_stamp[WINDOW];

  cmd_t    cmd_backlog[$];
  report_t due_reports[$];
  logic    took_beat = 1'b0;
  logic    gaps_on = 1'b1;
  logic [31:0] gen_clock;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      op_beats[4] = '{0, 0, 0, 0};
  int      kind_seen[4] = '{0, 0, 0, 0};
  int      timeout_writes = 0;

  delivery_ack_timeout_tracker #(.WINDOW(WINDOW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_ack_seq(in_ack_seq),
    .in_current_time(in_current_time),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_seq_number(out_seq_number),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Work out the reports one accepted command produces and update the table copy
  task automatic forecast_reports(input logic [1:0] op, input logic [31:0] ack,
                                  input logic [31:0] stamp);
    int slot;
    int order[WINDOW];
    int n;
    int j;
    logic [31:0] elapsed;
    logic [31:0] age;
    logic [31:0] prior_age;
    case (op)
      OP_SEND: begin
        slot = int'(m_next_seq % WINDOW);
        if (m_live[slot]) begin
          due_reports.insert(due_reports.size(), report_t'{KIND_FULL, m_next_seq, 1'b1});
        end else begin
          m_live[slot] = 1'b1;
          m_seq[slot] = m_next_seq;
          m_stamp[slot] = stamp;
          due_reports.insert(due_reports.size(),
                             report_t'{KIND_ASSIGNED, m_next_seq, 1'b1});
          m_next_seq = m_next_seq + 1;
        end
      end
      OP_ACK: begin
        slot = int'(ack % WINDOW);
        if (m_live[slot] && m_seq[slot] == ack) begin
          m_live[slot] = 1'b0;
          due_reports.insert(due_reports.size(), report_t'{KIND_SUCCESS, ack, 1'b1});
        end
      end
      OP_SWEEP: begin
        n = 0;
        for (int i = 0; i < WINDOW; i++) begin
          elapsed = stamp - m_stamp[i];
          if (m_live[i] && elapsed > m_timeout) begin
            age = m_next_seq - m_seq[i];
            j = n;
            // insert so that the oldest entry comes first
            while (j > 0) begin
              prior_age = m_next_seq - m_seq[order[j - 1]];
              if (prior_age >= age) break;
              order[j] = order[j - 1];
              j--;
            end
            order[j] = i;
            n++;
          end
        end
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        for (int i = 0; i < n; i++) begin
          m_live[order[i]] = 1'b0;
          due_reports.insert(due_reports.size(),
                             report_t'{KIND_FAILURE, m_seq[order[i]], i == n - 1});
        end
      end
      default: ;
    endcase
  endtask

  // Driver: present the next command at the falling edge, hold it until taken
  always @(negedge clk) begin : drive
    cmd_t c;
    int live_slots[$];
    if (rst_n && (!start || took_beat)) begin
      if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 19)) begin
        c = cmd_backlog.pop_front();
        if (c.op == OP_ACK && c.ack_mode != ACK_AS_GIVEN) begin
          live_slots.delete();
          for (int i = 0; i < WINDOW; i++) if (m_live[i]) live_slots.insert(live_slots.size(), i);
          if (live_slots.size() != 0) begin
            c.ack = m_seq[live_slots[$urandom_range(live_slots.size() - 1)]];
            // same slot, different sequence number
            if (c.ack_mode == ACK_ALIAS) c.ack = c.ack + WINDOW * $urandom_range(3, 1);
          end
        end
        start <= 1'b1;
        in_op <= c.op;
        in_ack_seq <= c.ack;
        in_current_time <= c.stamp;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check reports, then account for the beat taken at this edge
  always @(posedge clk) begin : watch
    report_t want;
    took_beat <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        kind_seen[out_kind]++;
        if (due_reports.size() == 0) begin
          errors++;
          $display("%0t: report expected none, got kind %0d seq %0d last %0d",
                   $realtime, out_kind, out_seq_number, out_last);
        end else begin
          want = due_reports.pop_front();
          if (out_kind !== want.kind) begin
            errors++;
            $display("%0t: kind expected %0d, got %0d", $realtime, want.kind, out_kind);
          end
          if (out_seq_number !== want.seq) begin
            errors++;
            $display("%0t: seq_number expected %0d, got %0d",
                     $realtime, want.seq, out_seq_number);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d, got %0d", $realtime, want.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) m_timeout = cfg_data;
      if (start && !busy) begin
        op_beats[in_op]++;
        forecast_reports(in_op, in_ack_seq, in_current_time);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] op, input logic [31:0] ack,
                           input logic [31:0] stamp);
    cmd_backlog.insert(cmd_backlog.size(), cmd_t'{op, ack, stamp, ACK_AS_GIVEN});
  endtask

  // Random traffic: time advances up to tick_max per command
  task automatic queue_traffic(input int count, input int unsigned tick_max);
    cmd_t c;
    int unsigned pick;
    int unsigned sub;
    gen_clock = $urandom;
    for (int k = 0; k < count; k++) begin
      gen_clock = gen_clock + $urandom_range(tick_max);
      pick = $urandom_range(99);
      sub = $urandom_range(9);
      c.stamp = gen_clock;
      c.ack = $urandom;
      c.ack_mode = ACK_AS_GIVEN;
      if (pick < 45) begin
        c.op = OP_SEND;
      end else if (pick < 80) begin
        c.op = OP_ACK;
        if (sub < 7) c.ack_mode = ACK_LIVE;
        else if (sub == 7) c.ack_mode = ACK_ALIAS;
      end else if (pick < 95) begin
        c.op = OP_SWEEP;
        if (sub == 0) c.stamp = $urandom;
      end else begin
        c.op = OP_UNUSED;
      end
      cmd_backlog.insert(cmd_backlog.size(), c);
    end
  endtask

  // Wait until every command is taken and every report is in, then let a sweep finish
  task automatic settle_idle();
    while (cmd_backlog.size() != 0 || start || due_reports.size() != 0 || busy)
      @(posedge clk);
    repeat (WINDOW + 8) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    timeout_writes++;
  endtask

  initial begin
    m_timeout = TIMEOUT_RESET;
    m_next_seq = '0;
    for (int i = 0; i < WINDOW; i++) begin
      m_live[i] = 1'b0;
      m_seq[i] = '0;
      m_stamp[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: unmatched ack, idle sweep, unused op
    queue_cmd(OP_ACK, 32'd5, 32'd0);
    queue_cmd(OP_SWEEP, 32'd0, 32'd0);
    queue_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the window with start times just below the wrap through zero
    for (int i = 0; i < WINDOW; i++) queue_cmd(OP_SEND, 32'd0, 32'hFFFF_FFF0 + i);
    queue_cmd(OP_SEND, 32'd0, 32'd0);
    queue_cmd(OP_ACK, 32'd3, 32'd0);
    queue_cmd(OP_ACK, 32'd20, 32'd0);
    queue_cmd(OP_ACK, 32'hFFFF_FFFF, 32'd0);
    queue_cmd(OP_SWEEP, 32'd0, 32'h0000_00C0);
    queue_cmd(OP_SWEEP, 32'd0, 32'hFFFF_FFFF);
    queue_cmd(OP_SWEEP, 32'd0, 32'h0001_0000);
    queue_cmd(OP_SEND, 32'd0, 32'h0001_0000);
    settle_idle();

    // One-tick timeout: clear, refill, then expire the whole window at once
    set_timeout(32'd1);
    queue_cmd(OP_SWEEP, 32'd0, 32'h0002_0000);
    for (int i = 0; i < WINDOW; i++) queue_cmd(OP_SEND, 32'd0, 32'h0002_0000);
    queue_cmd(OP_SWEEP, 32'd0, 32'h0002_0002);
    queue_traffic(60, 3);
    settle_idle();

    // Longest timeout: nothing ever expires
    set_timeout(32'hFFFF_FFFF);
    queue_traffic(60, 32'h4000_0000);
    settle_idle();

    // Back-to-back stretch with no gaps
    set_timeout(32'd500);
    gaps_on <= 1'b0;
    queue_traffic(65, 60);
    settle_idle();
    gaps_on <= 1'b1;

    set_timeout(32'h8000_0000);
    queue_traffic(60, 32'h2000_0000);
    settle_idle();

    set_timeout(32'd37);
    queue_traffic(70, 10);
    settle_idle();

    $display("covered %0d commands: %0d send, %0d ack, %0d sweep, %0d unused op",
             op_beats[0] + op_beats[1] + op_beats[2] + op_beats[3],
             op_beats[0], op_beats[1], op_beats[2], op_beats[3]);
    $display("reports seen: %0d assigned, %0d delivered, %0d failed, %0d full; %0d timeouts",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], timeout_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
